// ===== src/rpg_pkg.sv =====
// Shared types, constants and the color wheel function of the rainbow pattern generator.
// Used by every module under src; depends on nothing else.
`default_nettype none

package rpg_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_MODE      = 2'd0;
	localparam logic [1:0] REG_PIX_COUNT = 2'd1;
	localparam logic [1:0] REG_LEAF_CNT  = 2'd2;
	localparam logic [1:0] REG_PIX_LEAF  = 2'd3;

	// Pattern mode codes; any other code shows the whole strip in one color.
	localparam logic [1:0] MODE_PIXEL = 2'd0;
	localparam logic [1:0] MODE_LEAF  = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [1:0]  MODE_RST      = MODE_PIXEL;
	localparam logic [10:0] PIX_COUNT_RST = 11'd60;
	localparam logic [6:0]  LEAF_CNT_RST  = 7'd10;
	localparam logic [4:0]  PIX_LEAF_RST  = 5'd6;

	// Wheel breakpoints.
	localparam logic [7:0] WHEEL_BRK1 = 8'd85;
	localparam logic [7:0] WHEEL_BRK2 = 8'd170;
	localparam logic [7:0] WHEEL_TOP  = 8'd255;

	// How the back end works out the wheel position of one pixel.
	typedef enum logic [1:0] {
		KIND_PIXEL,
		KIND_LEAF,
		KIND_FLAT
	} kind_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_LEAF,
		BK_POS,
		BK_DONE
	} bk_state_t;

	// One classified pixel request, as queued between front and back.
	typedef struct packed {
		kind_t       kind;
		logic [9:0]  pixel;
		logic [7:0]  frame;
		logic        last;
		logic [10:0] len;
		logic [4:0]  ppl;
		logic [6:0]  leafs;
	} entry_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// Three-segment color wheel.
	function automatic rgb_t colour_wheel(input logic [7:0] pos);
		rgb_t       c;
		logic [7:0] p;
		p = 8'd0;
		if (pos < WHEEL_BRK1) begin
			c.red   = 8'(pos * 8'd3);
			c.green = WHEEL_TOP - 8'(pos * 8'd3);
			c.blue  = 8'd0;
		end else if (pos < WHEEL_BRK2) begin
			p       = pos - WHEEL_BRK1;
			c.red   = WHEEL_TOP - 8'(p * 8'd3);
			c.green = 8'd0;
			c.blue  = 8'(p * 8'd3);
		end else begin
			p       = pos - WHEEL_BRK2;
			c.red   = 8'd0;
			c.green = 8'(p * 8'd3);
			c.blue  = WHEEL_TOP - 8'(p * 8'd3);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== src/rpg_in_if.sv =====
// Request channel of the rainbow pattern generator: one beat asks for the next pixel.
// Stands alone; no package needed.
`default_nettype none

interface rpg_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ===== src/rpg_out_if.sv =====
// Result channel of the rainbow pattern generator: one beat carries one pixel color.
// Stands alone; no package needed.
`default_nettype none

interface rpg_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [9:0] pixel_number;
	logic [7:0] frame_number;
	logic       frame_end;

	modport source (output valid, output red, output green, output blue,
		output pixel_number, output frame_number, output frame_end, input ready);
	modport sink (input valid, input red, input green, input blue,
		input pixel_number, input frame_number, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== src/rpg_front.sv =====
// Front end: accepts request beats, steps the pixel and frame counters and classifies
// each pixel for the back end. Uses rpg_pkg and rpg_in_if.
`default_nettype none

module rpg_front #(
	parameter int MAX_PIXELS       = 1024,
	parameter int FRAMES_PER_CYCLE = 255
) (
	input  wire                  clk,
	input  wire                  arst_n,
	rpg_in_if.sink               cmd,
	input  wire [1:0]            mode,
	input  wire [10:0]           pix_count,
	input  wire [6:0]            leaf_cnt,
	input  wire [4:0]            pix_leaf,
	output logic                 push_valid,
	input  wire                  push_ready,
	output rpg_pkg::entry_t      push_entry
);

	localparam int          CapInt     = (MAX_PIXELS > 1024) ? 1024 : MAX_PIXELS;
	localparam logic [10:0] LEN_CAP    = 11'(CapInt);
	localparam logic [8:0]  FRAME_WRAP = 9'(FRAMES_PER_CYCLE);

	logic [9:0]  pixel_q;
	logic [7:0]  frame_q;
	logic [6:0]  leafs;
	logic [4:0]  ppl;
	logic [11:0] leaf_len;
	logic [11:0] raw_len;
	logic [10:0] len;
	logic [9:0]  pix0;
	logic [7:0]  frm0;
	logic [9:0]  pix1;
	logic [7:0]  frm1;
	logic        last;
	logic        accept;
	rpg_pkg::kind_t kind;

	function automatic logic [7:0] next_frame(input logic [7:0] f);
		logic [8:0] n;
		n = {1'b0, f} + 9'd1;
		return (n >= FRAME_WRAP) ? 8'd0 : n[7:0];
	endfunction

	// Zero sizes count as one; the frame length saturates at the cap.
	always_comb begin
		leafs    = (leaf_cnt == 7'd0) ? 7'd1 : leaf_cnt;
		ppl      = (pix_leaf == 5'd0) ? 5'd1 : pix_leaf;
		leaf_len = {5'd0, leafs} * {7'd0, ppl};
		case (mode)
			rpg_pkg::MODE_PIXEL: kind = rpg_pkg::KIND_PIXEL;
			rpg_pkg::MODE_LEAF:  kind = rpg_pkg::KIND_LEAF;
			default:             kind = rpg_pkg::KIND_FLAT;
		endcase
		if (kind == rpg_pkg::KIND_LEAF) begin
			raw_len = leaf_len;
		end else begin
			raw_len = (pix_count == 11'd0) ? 12'd1 : {1'b0, pix_count};
		end
		len = (raw_len > {1'b0, LEN_CAP}) ? LEN_CAP : raw_len[10:0];
	end

	// Restart, then start a new frame if the counter ran past a shrunk frame.
	always_comb begin
		pix0 = cmd.restart ? 10'd0 : pixel_q;
		frm0 = cmd.restart ? 8'd0 : frame_q;
		if ({1'b0, pix0} >= len) begin
			pix1 = 10'd0;
			frm1 = next_frame(frm0);
		end else begin
			pix1 = pix0;
			frm1 = frm0;
		end
		last = ({1'b0, pix1} == (len - 11'd1));
	end

	assign cmd.ready  = push_ready;
	assign accept     = cmd.valid && push_ready;
	assign push_valid = cmd.valid;

	always_comb begin
		push_entry.kind  = kind;
		push_entry.pixel = pix1;
		push_entry.frame = frm1;
		push_entry.last  = last;
		push_entry.len   = len;
		push_entry.ppl   = ppl;
		push_entry.leafs = leafs;
	end

	// Counters advance on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_q <= 10'd0;
			frame_q <= 8'd0;
		end else if (accept) begin
			if (last) begin
				pixel_q <= 10'd0;
				frame_q <= next_frame(frm1);
			end else begin
				pixel_q <= pix1 + 10'd1;
				frame_q <= frm1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/rpg_queue.sv =====
// Two-entry queue of classified pixels between front and back end.
// Uses rpg_pkg for the entry type.
`default_nettype none

module rpg_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push_valid,
	output logic                 push_ready,
	input  rpg_pkg::entry_t      push_entry,
	output logic                 pop_valid,
	input  wire                  pop,
	output rpg_pkg::entry_t      pop_entry
);

	rpg_pkg::entry_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/rpg_back.sv =====
// Back end: a shared restoring divider works out the wheel position one quotient bit
// per cycle, then the color wheel fills the output register. Uses rpg_pkg and rpg_out_if.
`default_nettype none

module rpg_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  pop_valid,
	output logic                 pop,
	input  rpg_pkg::entry_t      pop_entry,
	rpg_out_if.source            pixel
);

	rpg_pkg::bk_state_t state_q;
	rpg_pkg::bk_state_t state_n;
	rpg_pkg::entry_t    ent_q;
	rpg_pkg::rgb_t      rgb;

	logic [10:0] rem_q;
	logic [9:0]  num_q;
	logic [9:0]  quo_q;
	logic [10:0] div_q;
	logic [3:0]  cnt_q;
	logic [11:0] trial;
	logic [11:0] diff;
	logic        ge;
	logic [10:0] rem_n;
	logic [9:0]  quo_n;
	logic [7:0]  pos;
	logic        out_free;
	logic        load;

	logic       valid_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;
	logic [9:0] pix_num_q;
	logic [7:0] frm_num_q;
	logic       frm_end_q;

	// One restoring division step.
	always_comb begin
		trial = {rem_q, num_q[9]};
		diff  = trial - {1'b0, div_q};
		ge    = (trial >= {1'b0, div_q});
		rem_n = ge ? diff[10:0] : trial[10:0];
		quo_n = {quo_q[8:0], ge};
	end

	assign out_free = !valid_q || pixel.ready;

	// Sequencer: next state and handshake controls.
	always_comb begin
		state_n = state_q;
		pop     = 1'b0;
		load    = 1'b0;
		case (state_q)
			rpg_pkg::BK_IDLE: begin
				pop = pop_valid;
				if (pop_valid) begin
					case (pop_entry.kind)
						rpg_pkg::KIND_LEAF:  state_n = rpg_pkg::BK_LEAF;
						rpg_pkg::KIND_PIXEL: state_n = rpg_pkg::BK_POS;
						default:             state_n = rpg_pkg::BK_DONE;
					endcase
				end
			end
			rpg_pkg::BK_LEAF: begin
				if (cnt_q == 4'd0) begin
					state_n = rpg_pkg::BK_POS;
				end
			end
			rpg_pkg::BK_POS: begin
				if (cnt_q == 4'd0) begin
					state_n = rpg_pkg::BK_DONE;
				end
			end
			rpg_pkg::BK_DONE: begin
				load = out_free;
				if (out_free) begin
					state_n = rpg_pkg::BK_IDLE;
				end
			end
			default: state_n = rpg_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpg_pkg::BK_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Divider datapath. The leaf pass divides the pixel by the leaf size; the position
	// pass divides a remainder known to be below the divisor by it, eight bits deep.
	always_ff @(posedge clk) begin
		case (state_q)
			rpg_pkg::BK_IDLE: begin
				ent_q <= pop_entry;
				quo_q <= 10'd0;
				if (pop_entry.kind == rpg_pkg::KIND_LEAF) begin
					rem_q <= 11'd0;
					num_q <= pop_entry.pixel;
					div_q <= {6'd0, pop_entry.ppl};
					cnt_q <= 4'd9;
				end else begin
					rem_q <= {1'b0, pop_entry.pixel};
					num_q <= 10'd0;
					div_q <= pop_entry.len;
					cnt_q <= 4'd7;
				end
			end
			rpg_pkg::BK_LEAF: begin
				if (cnt_q == 4'd0) begin
					rem_q <= {1'b0, quo_n};
					num_q <= 10'd0;
					quo_q <= 10'd0;
					div_q <= {4'd0, ent_q.leafs};
					cnt_q <= 4'd7;
				end else begin
					rem_q <= rem_n;
					num_q <= {num_q[8:0], 1'b0};
					quo_q <= quo_n;
					cnt_q <= cnt_q - 4'd1;
				end
			end
			rpg_pkg::BK_POS: begin
				rem_q <= rem_n;
				num_q <= {num_q[8:0], 1'b0};
				quo_q <= quo_n;
				cnt_q <= cnt_q - 4'd1;
			end
			default: begin
			end
		endcase
	end

	// Wheel position and color.
	always_comb begin
		if (ent_q.kind == rpg_pkg::KIND_FLAT) begin
			pos = ent_q.frame;
		end else begin
			pos = quo_q[7:0] + ent_q.frame;
		end
		rgb = rpg_pkg::colour_wheel(pos);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (pixel.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			red_q     <= rgb.red;
			green_q   <= rgb.green;
			blue_q    <= rgb.blue;
			pix_num_q <= ent_q.pixel;
			frm_num_q <= ent_q.frame;
			frm_end_q <= ent_q.last;
		end
	end

	assign pixel.valid        = valid_q;
	assign pixel.red          = red_q;
	assign pixel.green        = green_q;
	assign pixel.blue         = blue_q;
	assign pixel.pixel_number = pix_num_q;
	assign pixel.frame_number = frm_num_q;
	assign pixel.frame_end    = frm_end_q;

endmodule

`default_nettype wire

// ===== src/rainbow_pattern_generator.sv =====
// Top level of the rainbow pattern generator: configuration registers, front end,
// queue and back end. Uses rpg_pkg, rpg_in_if, rpg_out_if, rpg_front, rpg_queue, rpg_back.
//
// Every beat on cmd asks for the color of the next pixel of a rainbow animation and
// yields exactly one beat on pixel. The front end takes a request while the queue has
// room and queues it (two entries deep); the back end works each pixel out through one
// shared restoring divider that produces one quotient bit per cycle: one division in
// per-pixel mode, two in per-leaf mode and none in single-color mode, then the result
// goes to the output register, which lets the next pixel be worked out while a result
// waits to be taken. The user must write the configuration registers through cfg_we,
// cfg_index and cfg_wdata only while the block is idle; the block does not enforce it.
`default_nettype none

module rainbow_pattern_generator #(
	parameter int MAX_PIXELS       = 1024,
	parameter int FRAMES_PER_CYCLE = 255
) (
	input  wire         clk,
	input  wire         arst_n,
	rpg_in_if.sink      cmd,
	rpg_out_if.source   pixel,
	input  wire         cfg_we,
	input  wire [1:0]   cfg_index,
	input  wire [10:0]  cfg_wdata
);

	logic [1:0]  mode_q;
	logic [10:0] pix_count_q;
	logic [6:0]  leaf_cnt_q;
	logic [4:0]  pix_leaf_q;

	logic            push_valid;
	logic            push_ready;
	rpg_pkg::entry_t push_entry;
	logic            pop_valid;
	logic            pop;
	rpg_pkg::entry_t pop_entry;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= rpg_pkg::MODE_RST;
			pix_count_q <= rpg_pkg::PIX_COUNT_RST;
			leaf_cnt_q  <= rpg_pkg::LEAF_CNT_RST;
			pix_leaf_q  <= rpg_pkg::PIX_LEAF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rpg_pkg::REG_MODE:      mode_q      <= cfg_wdata[1:0];
				rpg_pkg::REG_PIX_COUNT: pix_count_q <= cfg_wdata;
				rpg_pkg::REG_LEAF_CNT:  leaf_cnt_q  <= cfg_wdata[6:0];
				rpg_pkg::REG_PIX_LEAF:  pix_leaf_q  <= cfg_wdata[4:0];
				default: begin
				end
			endcase
		end
	end

	rpg_front #(
		.MAX_PIXELS       (MAX_PIXELS),
		.FRAMES_PER_CYCLE (FRAMES_PER_CYCLE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mode       (mode_q),
		.pix_count  (pix_count_q),
		.leaf_cnt   (leaf_cnt_q),
		.pix_leaf   (pix_leaf_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	rpg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_entry  (pop_entry)
	);

	rpg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_entry (pop_entry),
		.pixel     (pixel)
	);

endmodule

`default_nettype wire
